// ----- hw/rtl/petb_pkg.sv -----
package petb_pkg;

	// bank size and counter width
	localparam int NUM_TIMERS = 16;
	localparam int COUNT_BITS = 16;
	localparam int TIMER_BITS = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	// largest count value, widened to 32 bits for compares
	localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

	// item field widths
	localparam int ACTION_BITS = 3;
	localparam int INDEX_BITS = 4;
	localparam int INTERVAL_BITS = 16;

	// action codes
	localparam logic [ACTION_BITS-1:0] ACT_START = 3'd0;
	localparam logic [ACTION_BITS-1:0] ACT_STOP = 3'd1;
	localparam logic [ACTION_BITS-1:0] ACT_TICK = 3'd2;
	localparam logic [ACTION_BITS-1:0] ACT_QEXP = 3'd3;
	localparam logic [ACTION_BITS-1:0] ACT_QRUN = 3'd4;

	typedef struct packed {
		logic [ACTION_BITS-1:0] action;
		logic [INDEX_BITS-1:0] timer_index;
		logic [INTERVAL_BITS-1:0] interval_ticks;
	} req_item_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] queried_timer;
		logic flag;
	} rsp_item_t;

	// result of one timer update step
	typedef struct packed {
		logic [COUNT_BITS-1:0] remaining;
		logic fire;
	} upd_t;

	// reload value for a start: saturate to the count range, zero becomes one
	function automatic logic [COUNT_BITS-1:0] sat_interval(
		input logic [INTERVAL_BITS-1:0] v
	);
		logic [31:0] w;
		w = 32'(v);
		if (w > CNT_MAX) begin
			w = CNT_MAX;
		end
		if (w == 32'd0) begin
			w = 32'd1;
		end
		return w[COUNT_BITS-1:0];
	endfunction

endpackage

// ----- hw/rtl/petb_upd.sv -----
module petb_upd (
	input  logic [petb_pkg::COUNT_BITS-1:0] remaining,
	input  logic [petb_pkg::COUNT_BITS-1:0] reload,
	input  logic [petb_pkg::COUNT_BITS-1:0] pending,
	output petb_pkg::upd_t                  upd
);
	import petb_pkg::*;

	logic [COUNT_BITS:0] diff;

	// one subtractor: borrow or zero means the timer runs out
	assign diff = {1'b0, remaining} - {1'b0, pending};

	always_comb begin
		if (diff[COUNT_BITS] || (diff[COUNT_BITS-1:0] == '0)) begin
			upd.remaining = reload;
			upd.fire = 1'b1;
		end else begin
			upd.remaining = diff[COUNT_BITS-1:0];
			upd.fire = 1'b0;
		end
	end

endmodule

// ----- hw/rtl/periodic_event_timer_bank.sv -----
// Bank of periodic timers sharing one tick. A start item arms a timer with a reload
// count, a stop item disarms it, a tick item bumps a saturating pending count, and a
// query first folds the pending ticks into every armed timer, then answers one item
// with the expired latch (cleared on read) or the running flag. Start, stop and tick
// items are handled in the idle state. A query with no ticks pending goes straight to
// the response step; otherwise a single subtract-and-compare unit first walks the
// timers one per cycle. The block takes no new item until the query has loaded its
// result into the output register. A result waiting there does not block start, stop
// or tick items.
module periodic_event_timer_bank (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  petb_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output petb_pkg::rsp_item_t rsp
);
	import petb_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;
	localparam logic [TIMER_BITS-1:0] LAST_TIMER = TIMER_BITS'(NUM_TIMERS - 1);

	logic [1:0] state_q;
	logic [TIMER_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] remaining_q [NUM_TIMERS];
	logic [COUNT_BITS-1:0] reload_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] expired_q;
	logic [NUM_TIMERS-1:0] running_q;
	logic [COUNT_BITS-1:0] pending_q;
	logic [ACTION_BITS-1:0] q_action_q;
	logic [INDEX_BITS-1:0] q_index_q;
	logic q_ok_q;
	logic rsp_valid_q;
	rsp_item_t rsp_q;

	logic req_fire;
	logic idx_ok;
	logic [TIMER_BITS-1:0] req_tidx;
	logic [TIMER_BITS-1:0] q_tidx;
	logic rsp_space;
	upd_t upd;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire = req_valid && req_ready;
	assign idx_ok = (32'(req.timer_index) < NUM_TIMERS);
	assign req_tidx = TIMER_BITS'(req.timer_index);
	assign q_tidx = TIMER_BITS'(q_index_q);
	assign rsp_space = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// shared update unit, fed by the walk counter
	petb_upd u_upd (
		.remaining(remaining_q[cnt_q]),
		.reload(reload_q[cnt_q]),
		.pending(pending_q),
		.upd(upd)
	);

	// sequencer and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			pending_q <= '0;
			expired_q <= '0;
			running_q <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				remaining_q[i] <= '0;
				reload_q[i] <= '0;
			end
		end else begin
			// output valid: set by the response step, dropped once taken
			if ((state_q == ST_RESP) && rsp_space) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						unique case (req.action) inside
							ACT_START: begin
								if (idx_ok) begin
									remaining_q[req_tidx] <= sat_interval(req.interval_ticks);
									reload_q[req_tidx] <= sat_interval(req.interval_ticks);
									running_q[req_tidx] <= 1'b1;
									expired_q[req_tidx] <= 1'b0;
								end
							end
							ACT_STOP: begin
								if (idx_ok) begin
									reload_q[req_tidx] <= '0;
									running_q[req_tidx] <= 1'b0;
								end
							end
							ACT_TICK: begin
								if (pending_q != '1) begin
									pending_q <= pending_q + 1'b1;
								end
							end
							ACT_QEXP, ACT_QRUN: begin
								cnt_q <= '0;
								state_q <= (pending_q == '0) ? ST_RESP : ST_WALK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (reload_q[cnt_q] != '0) begin
						remaining_q[cnt_q] <= upd.remaining;
						if (upd.fire) begin
							expired_q[cnt_q] <= 1'b1;
						end
					end
					if (cnt_q == LAST_TIMER) begin
						pending_q <= '0;
						state_q <= ST_RESP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RESP: begin
					if (rsp_space) begin
						if (q_ok_q && (q_action_q == ACT_QEXP)) begin
							expired_q[q_tidx] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query item capture
	always_ff @(posedge clk) begin
		if (req_fire) begin
			q_action_q <= req.action;
			q_index_q <= req.timer_index;
			q_ok_q <= idx_ok;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if ((state_q == ST_RESP) && rsp_space) begin
			rsp_q.queried_timer <= q_index_q;
			if (!q_ok_q) begin
				rsp_q.flag <= 1'b0;
			end else if (q_action_q == ACT_QEXP) begin
				rsp_q.flag <= expired_q[q_tidx];
			end else begin
				rsp_q.flag <= running_q[q_tidx];
			end
		end
	end

	// pending ticks are gone once the walk finishes
	a_pending_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) && (cnt_q == LAST_TIMER) |=> (pending_q == '0))
		else $error("pending ticks left after walk");

	// a timer runs exactly when it has a reload value
	a_run_armed: assert property (@(posedge clk) disable iff (!arst_n)
		running_q[cnt_q] == (reload_q[cnt_q] != '0))
		else $error("running flag disagrees with reload");

	// a result appears only out of the response step
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_RESP))
		else $error("result loaded outside response step");

	// no new item is taken while the walk over the timers runs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !req_ready)
		else $error("ready during walk");

endmodule

// ----- tb/periodic_event_timer_bank_tb.sv -----
`timescale 1ns / 1ps

module periodic_event_timer_bank_tb;
	import petb_pkg::*;

	localparam int RAND_ITEMS = 1550;
	localparam int RUN_TICKS = 24;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 4 * (NUM_TIMERS + 2);
	localparam int MAX_WAIT = 16;
	localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO = ACT_QRUN + 1'b1;
	localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI = '1;

	typedef struct {
		req_item_t item;
		int unsigned gap;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_item_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_item_t rsp;

	// timer bank mirror
	logic [COUNT_BITS-1:0] tmr_remaining [NUM_TIMERS];
	logic [COUNT_BITS-1:0] tmr_reload [NUM_TIMERS];
	logic tmr_expired [NUM_TIMERS];
	logic tmr_running [NUM_TIMERS];
	logic [COUNT_BITS-1:0] tick_backlog;

	stim_t stim_q [$];
	rsp_item_t flag_answers [$];
	int unsigned n_items = 0;
	int unsigned n_sent = 0;
	int unsigned errors = 0;
	int unsigned calm_left = 0;

	periodic_event_timer_bank uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	// append one item with its leading gap; rush forces back-to-back
	function automatic void queue_item(
		input logic [ACTION_BITS-1:0] act,
		input logic [INDEX_BITS-1:0] idx,
		input logic [INTERVAL_BITS-1:0] ival,
		input bit rush
	);
		stim_t s;
		s.item.action = act;
		s.item.timer_index = idx;
		s.item.interval_ticks = ival;
		if (rush) begin
			s.gap = 0;
		end else if (calm_left > 0) begin
			calm_left--;
			s.gap = 0;
		end else begin
			if ($urandom_range(0, 30) == 0) begin
				calm_left = $urandom_range(10, 60);
			end
			s.gap = $urandom_range(0, MAX_WAIT);
		end
		stim_q.push_back(s);
		n_items++;
	endfunction

	// advance the mirror by one accepted item, record the flag a query returns
	task automatic step_timer_bank(input req_item_t it);
		rsp_item_t ans;
		logic [COUNT_BITS-1:0] ival;
		logic in_range;
		in_range = it.timer_index < NUM_TIMERS;
		case (it.action) inside
			ACT_START: begin
				ival = (it.interval_ticks == '0) ? COUNT_BITS'(1) : COUNT_BITS'(it.interval_ticks);
				if (in_range) begin
					tmr_remaining[it.timer_index] = ival;
					tmr_reload[it.timer_index] = ival;
					tmr_running[it.timer_index] = 1'b1;
					tmr_expired[it.timer_index] = 1'b0;
				end
			end
			ACT_STOP: begin
				if (in_range) begin
					tmr_reload[it.timer_index] = '0;
					tmr_running[it.timer_index] = 1'b0;
				end
			end
			ACT_TICK: begin
				if (tick_backlog != '1) begin
					tick_backlog++;
				end
			end
			ACT_QEXP, ACT_QRUN: begin
				// fold the backlog into every armed timer, one reload at most
				if (tick_backlog != '0) begin
					for (int t = 0; t < NUM_TIMERS; t++) begin
						if (tmr_reload[t] != '0) begin
							if (tmr_remaining[t] <= tick_backlog) begin
								tmr_remaining[t] = tmr_reload[t];
								tmr_expired[t] = 1'b1;
							end else begin
								tmr_remaining[t] = tmr_remaining[t] - tick_backlog;
							end
						end
					end
					tick_backlog = '0;
				end
				ans.queried_timer = it.timer_index;
				ans.flag = 1'b0;
				if (in_range) begin
					if (it.action == ACT_QEXP) begin
						ans.flag = tmr_expired[it.timer_index];
						tmr_expired[it.timer_index] = 1'b0;
					end else begin
						ans.flag = tmr_running[it.timer_index];
					end
				end
				flag_answers.push_back(ans);
			end
			default: begin
			end
		endcase
	endtask

	// request driver
	int unsigned gap_left = 0;
	bit gap_loaded = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left = 0;
			gap_loaded = 0;
		end else begin
			if (req_valid && req_ready) begin
				step_timer_bank(req);
				n_sent++;
			end
			if (!req_valid || req_ready) begin
				if (stim_q.size() != 0 && !gap_loaded) begin
					gap_left = stim_q[0].gap;
					gap_loaded = 1;
				end
				if (stim_q.size() == 0 || gap_left > 0) begin
					req_valid <= 1'b0;
					if (gap_left > 0) begin
						gap_left--;
					end
				end else begin
					req <= stim_q[0].item;
					req_valid <= 1'b1;
					void'(stim_q.pop_front());
					gap_loaded = 0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	int unsigned stall_left = 0;
	int unsigned steady_left = 0;
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
			steady_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (flag_answers.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual timer %0d flag %0b",
						$time, rsp.queried_timer, rsp.flag);
				end else begin
					want = flag_answers.pop_front();
					if (rsp.queried_timer !== want.queried_timer) begin
						errors++;
						$display("%0t: queried_timer mismatch, expected %0d, actual %0d",
							$time, want.queried_timer, rsp.queried_timer);
					end
					if (rsp.flag !== want.flag) begin
						errors++;
						$display("%0t: flag mismatch on timer %0d, expected %0b, actual %0b",
							$time, want.queried_timer, want.flag, rsp.flag);
					end
				end
				if (steady_left > 0) begin
					steady_left--;
					stall_left = 0;
				end else begin
					if ($urandom_range(0, 20) == 0) begin
						steady_left = $urandom_range(5, 30);
					end
					stall_left = $urandom_range(0, MAX_WAIT);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no item moving either way
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned n_rand;
		int unsigned pick;
		int unsigned burst;
		logic [INDEX_BITS-1:0] idx;
		logic [INTERVAL_BITS-1:0] ival;

		for (int t = 0; t < NUM_TIMERS; t++) begin
			tmr_remaining[t] = '0;
			tmr_reload[t] = '0;
			tmr_expired[t] = 1'b0;
			tmr_running[t] = 1'b0;
		end
		tick_backlog = '0;

		// directed: idle queries, zero and full intervals, reload, stop, spare codes
		queue_item(ACT_QRUN, 0, 16'hFFFF, 0);
		queue_item(ACT_QEXP, 0, 0, 0);
		queue_item(ACT_START, 0, 0, 0);
		queue_item(ACT_START, 15, 16'hFFFF, 0);
		queue_item(ACT_START, 5, 3, 0);
		queue_item(ACT_TICK, 15, 16'hFFFF, 0);
		queue_item(ACT_QEXP, 0, 16'h5555, 0);
		queue_item(ACT_QEXP, 0, 16'hAAAA, 0);
		queue_item(ACT_QRUN, 15, 0, 0);
		queue_item(ACT_TICK, 3, 0, 0);
		queue_item(ACT_TICK, 7, 1, 0);
		queue_item(ACT_TICK, 9, 2, 0);
		queue_item(ACT_QEXP, 5, 0, 0);
		queue_item(ACT_STOP, 5, 16'hFFFF, 0);
		queue_item(ACT_QRUN, 5, 0, 0);
		queue_item(ACT_TICK, 0, 0, 0);
		queue_item(ACT_QEXP, 5, 0, 0);
		queue_item(ACT_SPARE_LO, 15, 16'hFFFF, 0);
		queue_item(ACT_SPARE_HI, 10, 16'h1234, 0);
		queue_item(ACT_STOP, 9, 0, 0);
		queue_item(ACT_STOP, 15, 0, 0);
		queue_item(ACT_START, 15, 16'hFFFF, 0);
		queue_item(ACT_QEXP, 15, 0, 0);
		queue_item(ACT_QRUN, 9, 0, 0);

		// back-to-back tick run against a full-range timer, which must not fire
		queue_item(ACT_START, 3, 16'hFFFF, 0);
		queue_item(ACT_QEXP, 3, 0, 0);
		for (int n = 0; n < RUN_TICKS; n++) begin
			queue_item(ACT_TICK, 3, 0, 1);
		end
		queue_item(ACT_QEXP, 3, 0, 0);
		queue_item(ACT_QRUN, 3, 0, 0);

		// random: mostly short periods and tick runs so timers keep expiring
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			idx = INDEX_BITS'($urandom_range(0, (1 << INDEX_BITS) - 1));
			ival = INTERVAL_BITS'($urandom_range(0, (1 << INTERVAL_BITS) - 1));
			if (pick < 20) begin
				case ($urandom_range(0, 9))
					0: ival = '0;
					1, 2: begin
					end
					default: ival = INTERVAL_BITS'($urandom_range(1, 48));
				endcase
				queue_item(ACT_START, idx, ival, 0);
				n_rand++;
			end else if (pick < 27) begin
				queue_item(ACT_STOP, idx, ival, 0);
				n_rand++;
			end else if (pick < 60) begin
				burst = $urandom_range(1, 8);
				for (int n = 0; n < burst; n++) begin
					queue_item(ACT_TICK, INDEX_BITS'($urandom_range(0, (1 << INDEX_BITS) - 1)),
						INTERVAL_BITS'($urandom_range(0, (1 << INTERVAL_BITS) - 1)), 0);
				end
				n_rand += burst;
			end else if (pick < 80) begin
				queue_item(ACT_QEXP, idx, ival, 0);
				n_rand++;
			end else if (pick < 96) begin
				queue_item(ACT_QRUN, idx, ival, 0);
				n_rand++;
			end else begin
				queue_item(ACTION_BITS'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), idx, ival, 0);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_sent < n_items || flag_answers.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/petb_pkg.sv
hw/rtl/petb_upd.sv
hw/rtl/periodic_event_timer_bank.sv
tb/periodic_event_timer_bank_tb.sv
